### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: default sizes,
// operation and status codes, and the command bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int KEY_BITS_DEF     = 7;
	localparam int PAYLOAD_BITS_DEF = 16;

	localparam int STATUS_BITS = 2;

	// operation codes carried on func
	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	// result status codes
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell; at most one bit set
	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage

### rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue held as a row of cells sorted by key.
// ----------------------------------------------------------------------------
// One operation is taken per clock; busy never rises, so start may be held
// high every cycle. The result of each transfer shows on the result ports,
// marked by done, in the cycle after the transfer, for one cycle only: the
// receiver must take it then. That rate is set by each cell comparing its
// own key with the new key and moving one place in the same clock. Insert
// places the entry ahead of all equal or smaller keys (newest first among
// equals); an insert into a full queue is dropped with status 2, a remove
// from an empty queue gives status 1 and zero data.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	localparam int CNT_W       = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [KEY_BITS-1:0]            key,
	input  logic [PAYLOAD_BITS-1:0]        payload,
	output logic                           done,
	output logic [spq_pkg::STATUS_BITS-1:0] status,
	output logic [KEY_BITS-1:0]            out_key,
	output logic [PAYLOAD_BITS-1:0]        out_payload,
	output logic [CNT_W-1:0]               fill
);

	logic                    cell_valid   [DEPTH];
	logic [KEY_BITS-1:0]     cell_key     [DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
	logic                    cell_gt      [DEPTH];

	logic                    accept;
	logic                    full;
	logic                    empty;
	spq_pkg::cmd_t           cmd;
	spq_pkg::status_t        status_d;

	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	spq_pkg::status_t        status_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// decode the operation into the cell command
	always_comb begin
		cmd      = '0;
		status_d = spq_pkg::ST_OK;
		if (accept) begin
			unique case (spq_pkg::func_t'(func))
				spq_pkg::FUNC_INSERT: begin
					if (full) status_d = spq_pkg::ST_FULL;
					else      cmd.ins  = 1'b1;
				end
				spq_pkg::FUNC_REMOVE: begin
					if (empty) status_d = spq_pkg::ST_EMPTY;
					else       cmd.rem  = 1'b1;
				end
				default: status_d = spq_pkg::ST_OK;
			endcase
		end
	end

	// row of cells, slot 0 holds the highest key
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    l_gt;
		logic                    l_valid;
		logic [KEY_BITS-1:0]     l_key;
		logic [PAYLOAD_BITS-1:0] l_payload;
		logic                    r_valid;
		logic [KEY_BITS-1:0]     r_key;
		logic [PAYLOAD_BITS-1:0] r_payload;

		if (i == 0) begin : g_head
			assign l_gt      = 1'b1;
			assign l_valid   = 1'b0;
			assign l_key     = '0;
			assign l_payload = '0;
		end else begin : g_mid
			assign l_gt      = cell_gt[i-1];
			assign l_valid   = cell_valid[i-1];
			assign l_key     = cell_key[i-1];
			assign l_payload = cell_payload[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_valid   = 1'b0;
			assign r_key     = '0;
			assign r_payload = '0;
		end else begin : g_body
			assign r_valid   = cell_valid[i+1];
			assign r_key     = cell_key[i+1];
			assign r_payload = cell_payload[i+1];
		end

		spq_cell #(
			.KEY_BITS    (KEY_BITS),
			.PAYLOAD_BITS(PAYLOAD_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.new_key      (key),
			.new_payload  (payload),
			.left_gt      (l_gt),
			.left_valid   (l_valid),
			.left_key     (l_key),
			.left_payload (l_payload),
			.right_valid  (r_valid),
			.right_key    (r_key),
			.right_payload(r_payload),
			.valid        (cell_valid[i]),
			.key          (cell_key[i]),
			.payload      (cell_payload[i]),
			.gt           (cell_gt[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			out_key_q     <= cmd.rem ? cell_key[0] : '0;
			out_payload_q <= cmd.rem ? cell_payload[0] : '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign fill        = count_q;

endmodule

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the shift-register queue. Holds a valid bit, a key and a
// payload; on insert it keeps, takes the new entry or takes its left
// neighbour's entry, and on remove it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spq_pkg::cmd_t           cmd,
	input  logic [KEY_BITS-1:0]     new_key,
	input  logic [PAYLOAD_BITS-1:0] new_payload,
	input  logic                    left_gt,
	input  logic                    left_valid,
	input  logic [KEY_BITS-1:0]     left_key,
	input  logic [PAYLOAD_BITS-1:0] left_payload,
	input  logic                    right_valid,
	input  logic [KEY_BITS-1:0]     right_key,
	input  logic [PAYLOAD_BITS-1:0] right_payload,
	output logic                    valid,
	output logic [KEY_BITS-1:0]     key,
	output logic [PAYLOAD_BITS-1:0] payload,
	output logic                    gt
);

	logic                    valid_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// held entry stays ahead of the new one
	assign gt = valid_q && (key_q > new_key);

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem) begin
			valid_q <= right_valid;
		end else if (cmd.ins && !gt) begin
			valid_q <= left_gt ? 1'b1 : left_valid;
		end
	end

	// entry data
	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			key_q     <= right_key;
			payload_q <= right_payload;
		end else if (cmd.ins && !gt) begin
			if (left_gt) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
		end
	end

	assign valid   = valid_q;
	assign key     = key_q;
	assign payload = payload_q;

endmodule

### rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS     = spq_pkg::KEY_BITS_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	localparam int CNT_W       = $clog2(DEPTH + 1)
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [spq_pkg::STATUS_BITS-1:0] status,
	input logic [KEY_BITS-1:0]             out_key,
	input logic [PAYLOAD_BITS-1:0]         out_payload,
	input logic [CNT_W-1:0]                fill
);

	// every transfer gives exactly one result, in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transfer without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without transfer");

	// failed operations return zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != spq_pkg::ST_OK) |-> (out_key == '0 && out_payload == '0))
		else $error("non-zero data on failed operation");

	// empty report only with nothing held, full report only at capacity
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_EMPTY) |-> (fill == '0))
		else $error("empty status with entries held");

	a_full_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::ST_FULL) |-> (fill == CNT_W'(DEPTH)))
		else $error("full status below capacity");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH       (DEPTH),
	.KEY_BITS    (KEY_BITS),
	.PAYLOAD_BITS(PAYLOAD_BITS)
) u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.out_key    (out_key),
	.out_payload(out_payload),
	.fill       (fill)
);

### test/sorted_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted priority queue. A driver sends insert
// and remove commands from a pending list, with random gaps. Each transfer
// is run through a behavioural copy of the queue, and the expected response
// is queued. A monitor compares every done strobe, field by field, with the
// oldest response still awaited. Stimulus starts with a short directed run
// covering an empty remove, key and payload extremes, equal keys and a full
// insert. It then moves on to random phases that fill, drain or churn the
// queue.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

	localparam int DEPTH      = spq_pkg::DEPTH_DEF;
	localparam int KW         = spq_pkg::KEY_BITS_DEF;
	localparam int PW         = spq_pkg::PAYLOAD_BITS_DEF;
	localparam int FILL_BITS  = $clog2(DEPTH + 1);
	localparam int RAND_CMDS  = 1100;
	localparam int MAX_GAP    = 4;
	localparam int DRAIN_WAIT = 50;
	localparam int CYCLE_CAP  = 100000;
	localparam int PRINT_CAP  = 200;

	typedef struct {
		spq_pkg::func_t op;
		logic [KW-1:0]  key;
		logic [PW-1:0]  payload;
		int unsigned    gap;
	} spq_cmd_t;

	typedef struct {
		spq_pkg::status_t     status;
		logic [KW-1:0]        key;
		logic [PW-1:0]        payload;
		logic [FILL_BITS-1:0] fill;
	} spq_resp_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            func;
	logic [KW-1:0]                   key;
	logic [PW-1:0]                   payload;
	logic                            done;
	logic [spq_pkg::STATUS_BITS-1:0] status;
	logic [KW-1:0]                   out_key;
	logic [PW-1:0]                   out_payload;
	logic [FILL_BITS-1:0]            fill;

	// behavioural queue: slot 0 holds the highest key
	logic [KW-1:0] held_key [DEPTH];
	logic [PW-1:0] held_pay [DEPTH];
	int            held_count;

	spq_cmd_t  pending_cmds[$];
	spq_resp_t awaited_resps[$];
	int        errors;
	int        cycles;

	sorted_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.key         (key),
		.payload     (payload),
		.done        (done),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.fill        (fill)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP) begin
			$display("%0t mismatch: %s", $time, msg);
		end
		errors++;
	endtask

	// apply one command to the behavioural queue and return its response
	function automatic spq_resp_t queue_step(input spq_cmd_t c);
		spq_resp_t r;
		int        pos;
		r.status  = spq_pkg::ST_OK;
		r.key     = '0;
		r.payload = '0;
		if (c.op == spq_pkg::FUNC_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_key[pos] > c.key) pos++;
				for (int i = held_count; i > pos; i--) begin
					held_key[i] = held_key[i-1];
					held_pay[i] = held_pay[i-1];
				end
				held_key[pos] = c.key;
				held_pay[pos] = c.payload;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = spq_pkg::ST_EMPTY;
			end else begin
				r.key     = held_key[0];
				r.payload = held_pay[0];
				for (int i = 1; i < held_count; i++) begin
					held_key[i-1] = held_key[i];
					held_pay[i-1] = held_pay[i];
				end
				held_count--;
			end
		end
		r.fill = FILL_BITS'(held_count);
		return r;
	endfunction

	task automatic add_cmd(input spq_pkg::func_t op, input logic [KW-1:0] k,
			input logic [PW-1:0] p, input int unsigned gap);
		spq_cmd_t c;
		c.op      = op;
		c.key     = k;
		c.payload = p;
		c.gap     = gap;
		pending_cmds.push_back(c);
	endtask

	// driver: present pending commands, hold each until its transfer
	spq_cmd_t cur_cmd;
	logic     cmd_loaded = 1'b0;
	int       gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				awaited_resps.push_back(queue_step(cur_cmd));
				cmd_loaded = 1'b0;
			end
			if (!cmd_loaded && pending_cmds.size() > 0) begin
				cur_cmd    = pending_cmds.pop_front();
				cmd_loaded = 1'b1;
				gap_left   = cur_cmd.gap;
			end
			if (cmd_loaded && gap_left == 0) begin
				start   <= 1'b1;
				func    <= cur_cmd.op;
				key     <= cur_cmd.key;
				payload <= cur_cmd.payload;
			end else begin
				// idle: random junk on the command fields
				start   <= 1'b0;
				func    <= 1'($urandom);
				key     <= KW'($urandom);
				payload <= PW'($urandom);
				if (cmd_loaded) gap_left--;
			end
		end
	end

	// monitor: every done strobe must match the oldest awaited response
	always @(posedge clk) begin
		spq_resp_t exp_r;
		if (arst_n && done) begin
			if (awaited_resps.size() == 0) begin
				report_mismatch($sformatf("unexpected response status=%0d fill=%0d",
					status, fill));
			end else begin
				exp_r = awaited_resps.pop_front();
				if (status !== exp_r.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, exp_r.status));
				if (out_key !== exp_r.key)
					report_mismatch($sformatf("out_key %0d, expected %0d",
						out_key, exp_r.key));
				if (out_payload !== exp_r.payload)
					report_mismatch($sformatf("out_payload %h, expected %h",
						out_payload, exp_r.payload));
				if (fill !== exp_r.fill)
					report_mismatch($sformatf("fill %0d, expected %0d",
						fill, exp_r.fill));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("sorted_priority_queue_tb: errors");
			$finish;
		end
	end

	// directed keys for the fill-up run: extremes and ties at top, middle, bottom
	localparam logic [KW-1:0] FILL_KEYS [16] = '{
		7'd0, 7'd127, 7'd64, 7'd64, 7'd127, 7'd0, 7'd1, 7'd126,
		7'd63, 7'd65, 7'd32, 7'd96, 7'd64, 7'd3, 7'd100, 7'd127
	};

	initial begin
		int          made;
		int          run_len;
		int          ins_pct;
		int          key_mode;
		bit          no_gaps;
		logic [KW-1:0] k;
		logic [PW-1:0] p;
		int          drain;

		arst_n     = 1'b0;
		start      = 1'b0;
		func       = 1'b0;
		key        = '0;
		payload    = '0;
		errors     = 0;
		cycles     = 0;
		held_count = 0;

		// directed: empty remove, fill to the brim, full insert, a few removes
		add_cmd(spq_pkg::FUNC_REMOVE, '0, '0, 0);
		for (int i = 0; i < 16; i++) begin
			if (i == 0)
				p = '0;
			else if (i == 1 || i == 15)
				p = '1;
			else
				p = PW'(i * 16'h1111);
			add_cmd(spq_pkg::FUNC_INSERT, FILL_KEYS[i], p,
				(i < 8) ? 0 : $urandom_range(0, MAX_GAP));
		end
		add_cmd(spq_pkg::FUNC_INSERT, 7'd127, 16'hAAAA, 0);
		for (int i = 0; i < 6; i++)
			add_cmd(spq_pkg::FUNC_REMOVE, KW'($urandom), PW'($urandom),
				$urandom_range(0, MAX_GAP));

		// random phases that fill, drain or churn the queue
		made = 0;
		while (made < RAND_CMDS) begin
			run_len  = $urandom_range(8, 64);
			case ($urandom_range(0, 2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			key_mode = $urandom_range(0, 3);
			no_gaps  = $urandom_range(0, 1);
			for (int i = 0; i < run_len; i++) begin
				case (key_mode)
					0: k = KW'($urandom_range(0, 3));
					1: k = $urandom_range(0, 1) ? '1 : '0;
					default: k = KW'($urandom);
				endcase
				p = PW'($urandom);
				add_cmd(($urandom_range(1, 100) <= ins_pct) ?
					spq_pkg::FUNC_INSERT : spq_pkg::FUNC_REMOVE,
					k, p, no_gaps ? 0 : $urandom_range(0, MAX_GAP));
			end
			made += run_len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command to transfer, then for the responses
		while (pending_cmds.size() > 0 || cmd_loaded || start) @(posedge clk);
		drain = 0;
		while (awaited_resps.size() > 0 && drain < DRAIN_WAIT) begin
			@(posedge clk);
			drain++;
		end
		if (awaited_resps.size() > 0)
			report_mismatch($sformatf("%0d responses never arrived", awaited_resps.size()));
		repeat (5) @(posedge clk);

		if (errors == 0)
			$display("sorted_priority_queue_tb: clean");
		else
			$display("sorted_priority_queue_tb: errors");
		$finish;
	end

endmodule

### filelist.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
test/sorted_priority_queue_tb.sv
